/* hdl/postfix_expression_evaluator_assert.svh */
// assertion macros used by the checker file
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define PEE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked during reset as well
`define PEE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* hdl/pee_pkg.sv */
// package with types, constants and character codes of the postfix evaluator
package pee_pkg;

  localparam int unsigned StackDepthDefault = 128;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrUnder  = 2'd1,
    ErrOver   = 2'd2,
    ErrDivZero = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    OpDiv = 2'd0,
    OpPow = 2'd1
  } alu_op_e;

  // request to and reply from the iterative arithmetic unit
  typedef struct packed {
    logic                 start;
    alu_op_e              op;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] a;
  } alu_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] res;
  } alu_rsp_t;

endpackage

/* hdl/pee_stream_if.sv */
// valid/ready channel carrying one payload
interface pee_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/pee_alu.sv */
// iterative divider and power unit, one step a cycle
module pee_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_pkg::alu_req_t req_i,
  output pee_pkg::alu_rsp_t rsp_o
);
  localparam int unsigned W = pee_pkg::DataWidth;

  logic            busy_q, busy_d;
  pee_pkg::alu_op_e op_q, op_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [W-1:0]    acc_q, acc_d;   // remainder or running product
  logic [W-1:0]    x_q, x_d;       // quotient or squared base
  logic [W-1:0]    y_q, y_d;       // divisor magnitude or exponent
  logic            neg_q, neg_d;
  logic            done_q, done_d;

  logic [W-1:0]   nmag, dmag;
  logic [W:0]     trial;
  logic [W-1:0]   rem_sh;
  logic [2*W-1:0] prod;

  always_comb begin
    nmag = req_i.b[W-1] ? (~req_i.b + 1'b1) : req_i.b;
    dmag = req_i.a[W-1] ? (~req_i.a + 1'b1) : req_i.a;
  end

  // one step of the datapath
  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    rem_sh = {acc_q[W-2:0], x_q[W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, y_q};
    prod   = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      if (req_i.op == pee_pkg::OpDiv) begin
        acc_d = '0;
        x_d   = nmag;
        y_d   = dmag;
        neg_d = req_i.b[W-1] ^ req_i.a[W-1];
      end else begin
        acc_d = {{(W-1){1'b0}}, 1'b1};
        x_d   = req_i.b;
        y_d   = req_i.a[W-1] ? '0 : req_i.a;
        neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (op_q == pee_pkg::OpDiv) begin
        if (trial[W]) begin
          acc_d = rem_sh;
          x_d   = {x_q[W-2:0], 1'b0};
        end else begin
          acc_d = trial[W-1:0];
          x_d   = {x_q[W-2:0], 1'b1};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(W - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        // alternate multiply of result and squaring of base
        if (!cnt_q[0]) begin
          prod = acc_q * x_q;
          if (y_q[0]) acc_d = prod[W-1:0];
        end else begin
          prod = x_q * x_q;
          x_d  = prod[W-1:0];
          y_d  = {1'b0, y_q[W-1:1]};
        end
        cnt_d = cnt_q + 6'd1;
        if (y_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= pee_pkg::OpDiv;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    if (op_q == pee_pkg::OpDiv) rsp_o.res = neg_q ? (~x_q + 1'b1) : x_q;
    else rsp_o.res = acc_q;
  end
endmodule

/* hdl/postfix_expression_evaluator.sv */
// top level of the postfix expression evaluator
// Usage:
//   in_if is a valid/ready channel carrying one character (symbol) and an
//   end_of_expression flag; out_if carries value and status of an expression.
//   A request is taken only while the sequencer is idle, one character at a
//   time. Space and tab are skipped and digits are pushed; + - * take
//   two stack reads through the registered memory port, compute and write
//   back; division runs the 32-step restoring divider; power runs two
//   steps per exponent bit through the multiplier of the ALU. The last
//   character adds a pop of the final result.
//   The result sits in an output register; while the receiver stalls the
//   block finishes the current character but takes no further request
//   until that result is taken.
//   Reset clears the depth count, the error status and the sequencer; the
//   stack memory itself is not cleared, as only entries pushed by the same
//   expression are ever read.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pee_pkg::StackDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pee_stream_if.sink     in_if,
  pee_stream_if.source   out_if
);
  localparam int unsigned W  = pee_pkg::DataWidth;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StPopA  = 8'b00000010,
    StPopB  = 8'b00000100,
    StExec  = 8'b00001000,
    StWait  = 8'b00010000,
    StPush  = 8'b00100000,
    StFinal = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   depth_q, depth_d;
  pee_pkg::err_e   err_q, err_d;
  logic [7:0]      sym_q, sym_d;
  logic            last_q, last_d;
  logic [W-1:0]    a_q, a_d, b_q, b_d, res_q, res_d;
  logic            ra_ok_q, ra_ok_d;   // the pending read hit a valid entry
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_value_q, out_value_d;
  logic [1:0]      out_status_q, out_status_d;

  // stack memory
  logic [W-1:0]    mem [STACK_DEPTH];
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [W-1:0]    wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  pee_pkg::alu_req_t alu_req;
  pee_pkg::alu_rsp_t alu_rsp;

  pee_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  logic [W-1:0] popped;
  logic [2*W-1:0] mul;
  logic is_digit, is_blank, is_op2;

  always_comb begin
    popped   = ra_ok_q ? rdata_q : '0;
    is_digit = (in_if.data.symbol >= pee_pkg::ChZero) &&
               (in_if.data.symbol <= pee_pkg::ChNine);
    is_blank = (in_if.data.symbol == pee_pkg::ChSpace) ||
               (in_if.data.symbol == pee_pkg::ChTab);
    is_op2   = 1'b0;
    mul      = a_q * b_q;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    err_d        = err_q;
    sym_d        = sym_q;
    last_d       = last_q;
    a_d          = a_q;
    b_d          = b_q;
    res_d        = res_q;
    ra_ok_d      = ra_ok_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = depth_q[AW-1:0];
    raddr        = AW'(depth_q - 1'b1);
    wdata        = res_q;
    alu_req      = '0;
    alu_req.a    = a_q;
    alu_req.b    = b_q;
    if (out_if.ready) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_if.valid && !out_valid_q) begin
          sym_d  = in_if.data.symbol;
          last_d = in_if.data.end_of_expression;
          if (is_blank) begin
            state_d = last_d ? StFinal : StIdle;
          end else if (is_digit) begin
            res_d   = W'(in_if.data.symbol - pee_pkg::ChZero);
            state_d = StPush;
          end else begin
            state_d = StPopA;
          end
          if (state_d == StFinal || state_d == StPopA) begin
            // start a pop read
            re      = 1'b1;
            ra_ok_d = (depth_q != '0);
            if (depth_q == '0) begin
              if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrUnder;
            end else depth_d = depth_q - 1'b1;
          end
        end
      end
      StPopA: begin
        a_d     = popped;
        re      = 1'b1;
        raddr   = AW'(depth_q - 1'b1);
        ra_ok_d = (depth_q != '0);
        if (depth_q == '0) begin
          if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrUnder;
        end else depth_d = depth_q - 1'b1;
        state_d = StPopB;
      end
      StPopB: begin
        b_d     = popped;
        state_d = StExec;
      end
      StExec: begin
        state_d = StPush;
        case (sym_q)
          pee_pkg::ChPlus:  res_d = b_q + a_q;
          pee_pkg::ChMinus: res_d = b_q - a_q;
          pee_pkg::ChStar:  res_d = mul[W-1:0];
          pee_pkg::ChSlash: begin
            if (a_q == '0) begin
              res_d = '0;
              if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrDivZero;
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = pee_pkg::OpDiv;
              state_d       = StWait;
            end
          end
          pee_pkg::ChCaret: begin
            alu_req.start = 1'b1;
            alu_req.op    = pee_pkg::OpPow;
            state_d       = StWait;
          end
          default: state_d = StPush;
        endcase
        if (!(sym_q == pee_pkg::ChPlus || sym_q == pee_pkg::ChMinus ||
              sym_q == pee_pkg::ChStar || sym_q == pee_pkg::ChSlash ||
              sym_q == pee_pkg::ChCaret)) begin
          state_d = last_q ? StFinal : StIdle;
          if (last_q) begin
            re      = 1'b1;
            ra_ok_d = (depth_q != '0);
            if (depth_q == '0) begin
              if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrUnder;
            end else depth_d = depth_q - 1'b1;
          end
        end
      end
      StWait: begin
        if (alu_rsp.done) begin
          res_d   = alu_rsp.res;
          state_d = StPush;
        end
      end
      StPush: begin
        if (depth_q >= CW'(STACK_DEPTH)) begin
          if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrOver;
        end else begin
          we      = 1'b1;
          depth_d = depth_q + 1'b1;
        end
        state_d = last_q ? StOut : StIdle;
      end
      StOut: begin
        // pop for the final result after the last push
        re      = 1'b1;
        ra_ok_d = (depth_q != '0);
        if (depth_q == '0) begin
          if (err_q == pee_pkg::ErrNone) err_d = pee_pkg::ErrUnder;
        end
        state_d = StFinal;
      end
      StFinal: begin
        out_valid_d  = 1'b1;
        out_value_d  = popped;
        out_status_d = err_q;
        depth_d      = '0;
        err_d        = pee_pkg::ErrNone;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (is_op2) state_d = StIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      depth_q     <= '0;
      err_q       <= pee_pkg::ErrNone;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      ra_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      ra_ok_q     <= ra_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    a_q          <= a_d;
    b_q          <= b_d;
    res_q        <= res_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign in_if.ready             = (state_q == StIdle) && !out_valid_q;
  assign out_if.valid            = out_valid_q;
  assign out_if.data.value       = out_value_q;
  assign out_if.data.status      = out_status_q;
endmodule

/* hdl/pee_checker.sv */
// port-level checker of the postfix evaluator and its bind
`include "postfix_expression_evaluator_assert.svh"

module pee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);
  `PEE_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid)
  `PEE_ASSERT(a_no_take_while_out, clk_i, rst_ni, out_valid |-> !in_ready)
  `PEE_ASSERT(a_out_after_take, clk_i, rst_ni, $rose(out_valid) |-> $past(!in_ready))
  `PEE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid)
  `PEE_ASSERT(a_status_stable, clk_i, rst_ni,
    (out_valid && !out_ready) |=> $stable(out_status))
endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.data.status)
);

/* test/tb_top.sv */
// testbench for the postfix expression evaluator: directed table, random expressions
module tb_top;
  import pee_pkg::*;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } sym_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } eval_rsp_t;

  typedef struct {
    logic [7:0]  sym;
    logic        last;
    bit          typed;
    logic [31:0] value;
    err_e        status;
  } table_row_t;

  localparam int unsigned Depth = StackDepthDefault;
  localparam logic [7:0] ChOdd = 8'hFF;

  logic clk_i;
  logic rst_ni;

  pee_stream_if #(.payload_t(sym_req_t))  in_if ();
  pee_stream_if #(.payload_t(eval_rsp_t)) out_if ();

  postfix_expression_evaluator #(.STACK_DEPTH(Depth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // shadow copy of the evaluation stack
  logic [31:0] shadow_stack [Depth];
  int unsigned shadow_depth;
  err_e        shadow_err;
  eval_rsp_t   pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned mismatches = 0;
  bit          timed_out;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard limit on run length
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void note_err(err_e code);
    if (shadow_err == ErrNone) shadow_err = code;
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (shadow_depth >= Depth) begin
      note_err(ErrOver);
      return;
    end
    shadow_stack[shadow_depth] = v;
    shadow_depth++;
  endfunction

  function automatic logic [31:0] pop_operand();
    if (shadow_depth == 0) begin
      note_err(ErrUnder);
      return 32'd0;
    end
    shadow_depth--;
    return shadow_stack[shadow_depth];
  endfunction

  function automatic logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
    logic [31:0] nmag;
    logic [31:0] dmag;
    logic [31:0] q;
    nmag = num[31] ? -num : num;
    dmag = den[31] ? -den : den;
    q = nmag / dmag;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] power_wrapped(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) return 32'd1;
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // advance the shadow stack by one character; returns 1 with the result on the last one
  function automatic bit evaluate_symbol(logic [7:0] sym, logic last, output eval_rsp_t rsp);
    logic [31:0] a;
    logic [31:0] b;
    rsp = '0;
    if (sym == ChSpace || sym == ChTab) begin
      // skipped
    end else if (sym >= ChZero && sym <= ChNine) begin
      push_operand(32'(sym - ChZero));
    end else begin
      a = pop_operand();
      b = pop_operand();
      case (sym)
        ChPlus:  push_operand(b + a);
        ChMinus: push_operand(b - a);
        ChStar:  push_operand(b * a);
        ChSlash: begin
          if (a == 0) begin
            note_err(ErrDivZero);
            push_operand(32'd0);
          end else begin
            push_operand(quotient_trunc(b, a));
          end
        end
        ChCaret: push_operand(power_wrapped(b, a));
        default: ;
      endcase
    end
    if (!last) return 1'b0;
    rsp.value  = pop_operand();
    rsp.status = shadow_err;
    shadow_depth = 0;
    shadow_err = ErrNone;
    return 1'b1;
  endfunction

  // offer one request and wait for it to be taken
  task automatic offer_symbol(logic [7:0] sym, logic last, bit typed, logic [31:0] tv,
                              err_e ts);
    eval_rsp_t rsp;
    bit        has_rsp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{symbol: sym, end_of_expression: last};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    has_rsp = evaluate_symbol(sym, last, rsp);
    if (has_rsp) begin
      if (typed) begin
        rsp.value  = tv;
        rsp.status = ts;
      end
      pending_results.push_back(rsp);
    end
  endtask

  // random symbol that is neither digit nor operator, nor blank
  function automatic logic [7:0] odd_symbol();
    logic [7:0] s;
    do s = 8'($urandom_range(255));
    while ((s >= ChZero && s <= ChNine) || s == ChPlus || s == ChMinus || s == ChStar ||
           s == ChSlash || s == ChCaret || s == ChSpace || s == ChTab);
    return s;
  endfunction

  function automatic logic [7:0] any_operator();
    case ($urandom_range(4))
      0: return ChPlus;
      1: return ChMinus;
      2: return ChStar;
      3: return ChSlash;
      default: return ChCaret;
    endcase
  endfunction

  // build one random expression and send it; returns the number of characters
  task automatic send_expression(output int unsigned count);
    logic [7:0]  chars [$];
    int unsigned kind;
    int unsigned held;
    int unsigned operands;
    kind = $urandom_range(199);
    chars = {};
    if (kind < 2) begin
      // more pushes than the stack holds
      repeat (Depth + 1 + $urandom_range(6)) chars.push_back(ChZero + 8'($urandom_range(9)));
      repeat ($urandom_range(3)) chars.push_back(any_operator());
    end else if (kind < 30) begin
      // noise and broken sequences
      repeat (1 + $urandom_range(8)) begin
        case ($urandom_range(3))
          0: chars.push_back(8'($urandom_range(255)));
          1: chars.push_back(odd_symbol());
          2: chars.push_back(any_operator());
          default: chars.push_back(ChZero + 8'($urandom_range(9)));
        endcase
      end
    end else begin
      // well formed expression with random content
      operands = 1 + $urandom_range(6);
      held = 0;
      while (operands > 0 || held > 1) begin
        if ($urandom_range(7) == 0) chars.push_back($urandom_range(1) ? ChSpace : ChTab);
        if (operands > 0 && (held < 2 || $urandom_range(1))) begin
          chars.push_back(ChZero + 8'($urandom_range(9)));
          operands--;
          held++;
        end else begin
          chars.push_back(any_operator());
          held--;
        end
      end
      if ($urandom_range(5) == 0) chars.push_back($urandom_range(1) ? ChSpace : ChTab);
    end
    count = chars.size();
    foreach (chars[i]) offer_symbol(chars[i], i == chars.size() - 1, 1'b0, '0, ErrNone);
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    eval_rsp_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%h status=%0d", out_if.data.value,
                     out_if.data.status);
        end else begin
          want = pending_results.pop_front();
          if (out_if.data.value !== want.value || out_if.data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       want.value, want.status, out_if.data.value, out_if.data.status);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long receiver stall, counted down here
        hold_cycles <= 600;
        hold_done <= 1'b1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // directed stimulus
  table_row_t directed [] = '{
    '{ChNine,  1'b1, 1'b1, 32'd9,          ErrNone},
    '{ChSpace, 1'b1, 1'b1, 32'd0,          ErrUnder},
    '{ChTab,   1'b1, 1'b1, 32'd0,          ErrUnder},
    '{ChZero,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChZero,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChSlash, 1'b1, 1'b1, 32'd0,          ErrDivZero},
    '{ChPlus,  1'b1, 1'b1, 32'd0,          ErrUnder},
    '{ChZero,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChZero,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChCaret, 1'b1, 1'b1, 32'd1,          ErrNone},
    '{8'h33,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{8'h34,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChOdd,   1'b1, 1'b1, 32'd0,          ErrUnder},
    '{8'h32,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{8'h38,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{8'h34,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChStar,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{8'h31,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChMinus, 1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChCaret, 1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChZero,  1'b0, 1'b0, 32'd0,          ErrNone},
    '{8'h31,   1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChMinus, 1'b0, 1'b0, 32'd0,          ErrNone},
    '{ChSlash, 1'b1, 1'b1, 32'h8000_0000,  ErrNone}
  };

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned waited;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    timed_out = 1'b0;
    shadow_depth = 0;
    shadow_err = ErrNone;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      offer_symbol(directed[i].sym, directed[i].last, directed[i].typed, directed[i].value,
                   directed[i].status);

    // three idling phases, receiver held off at the start of the last
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 34 : 0;
      if (phase == 2) hold_req = 1'b1;
      while (sent < (phase + 1) * 567) begin
        send_expression(n);
        sent += n;
      end
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 200_000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) timed_out = 1'b1;
    repeat (200) @(posedge clk_i);

    if (mismatches == 0 && !timed_out && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
